>>> sv/bsc_pkg.sv
// Shared types and constants for the byte-serial command processor.
// No dependencies; imported by bsc_mem, bsc_exec and the top level.
package bsc_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int BYTE_W        = 8;

    localparam logic [BYTE_W-1:0] BYTE_END = 8'hFE;
    localparam logic [BYTE_W-1:0] BYTE_IND = 8'hFF;
    localparam logic [BYTE_W-1:0] OPC_LIMIT = 8'd8;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_SET  = 3'd2,
        OP_IFEQ = 3'd3,
        OP_IFNE = 3'd4,
        OP_IFGT = 3'd5,
        OP_IFLT = 3'd6,
        OP_OUT  = 3'd7
    } t_opcode;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_OP1  = 4'b0010,
        PH_OP2  = 4'b0100,
        PH_SKIP = 4'b1000
    } t_phase;

    // data memory write port
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_wr;

    // result produced by the executing word
    typedef struct packed {
        logic              out_en;
        logic [BYTE_W-1:0] out_value;
    } t_exec_out;

endpackage

>>> sv/bsc_mem.sv
// Data memory: one read and one write port, registered read, write-first forwarding.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on bsc_pkg.
module bsc_mem #(
    parameter int MEM_DEPTH = bsc_pkg::MEM_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [bsc_pkg::BYTE_W-1:0]  i_rd_addr,
    input  bsc_pkg::t_mem_wr            i_wr,
    output logic [bsc_pkg::BYTE_W-1:0]  o_rd_data
);
    import bsc_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [BYTE_W-1:0]    r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]    r_rdata;
    logic                 r_hit;
    logic                 r_fwd;
    logic [BYTE_W-1:0]    r_fwd_data;
    logic [AW-1:0]        rd_a;
    logic [AW-1:0]        wr_a;

    assign rd_a = AW'(i_rd_addr);
    assign wr_a = AW'(i_wr.addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[wr_a] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rdata    <= r_mem[rd_a];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[wr_a] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_valid[rd_a];
                r_fwd <= i_wr.we && (wr_a == rd_a);
            end
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_hit ? r_rdata : '0);

endmodule

>>> sv/bsc_exec.sv
// Command sequencer: phase, opcode, held operand and indirect flag.
// Decodes one program word per firing, issues memory writes and out results.
// Depends on bsc_pkg.
module bsc_exec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [bsc_pkg::BYTE_W-1:0]  i_byte,
    input  logic [bsc_pkg::BYTE_W-1:0]  i_mem_data,
    output bsc_pkg::t_mem_wr            o_wr,
    output bsc_pkg::t_exec_out          o_res
);
    import bsc_pkg::*;

    t_phase            r_phase, n_phase;
    t_opcode           r_opcode, n_opcode;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_ind, n_ind;

    logic [BYTE_W-1:0] v;
    logic              test_ok;
    logic              wr_req;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;

    assign v = r_ind ? i_mem_data : i_byte;

    always_comb begin
        case (r_opcode)
            OP_IFEQ: test_ok = (r_held == v);
            OP_IFNE: test_ok = (r_held != v);
            OP_IFGT: test_ok = (r_held > v);
            default: test_ok = (r_held < v);
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_held     = r_held;
        n_ind      = r_ind;
        wr_req     = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        o_res      = '0;
        o_res.out_value = v;

        if (i_byte == BYTE_END) begin
            n_phase = PH_IDLE;
            n_ind   = 1'b0;
            n_held  = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte < OPC_LIMIT) begin
                        n_opcode = t_opcode'(i_byte[2:0]);
                        n_phase  = PH_OP1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_SKIP;
                end
                PH_OP1: begin
                    if (i_byte == BYTE_IND) begin
                        n_ind = 1'b1;
                    end else begin
                        n_ind = 1'b0;
                        if (r_opcode == OP_OUT) begin
                            o_res.out_en = 1'b1;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_held  = v;
                            n_phase = PH_OP2;
                        end
                    end
                end
                PH_OP2: begin
                    if (i_byte == BYTE_IND) begin
                        n_ind = 1'b1;
                    end else begin
                        n_ind   = 1'b0;
                        n_held  = '0;
                        n_phase = PH_IDLE;
                        case (r_opcode)
                            OP_ADD: begin
                                wr_req  = 1'b1;
                                wr_data = r_held + v;
                            end
                            OP_SUB: begin
                                wr_req  = 1'b1;
                                wr_data = r_held - v;
                            end
                            OP_SET: begin
                                wr_req  = 1'b1;
                                wr_addr = r_held;
                                wr_data = v;
                            end
                            default: begin
                                if (!test_ok) begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        endcase
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    assign o_wr.we   = i_fire && wr_req;
    assign o_wr.addr = wr_addr;
    assign o_wr.data = wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_opcode <= OP_ADD;
            r_held   <= '0;
            r_ind    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_held   <= n_held;
            r_ind    <= n_ind;
        end
    end

endmodule

>>> sv/byte_serial_command_cpu_core.sv
// Byte-serial command processor, top level. Program words enter on the input
// channel, one word per cycle at full rate; out results leave on the output channel.
// Depends on bsc_pkg, bsc_mem and bsc_exec.
//
// Usage: feed the command stream one byte per word. When idle, a byte 0..7 selects
// add, sub, set, ifeq, ifne, ifgt, iflt or out; 0xFF marks the next operand as a
// memory address; 0xFE ends any command or skip. Only out produces a result word.
// Throughput is one program word per clock while the input does not stall. An
// accepted word issues the data memory read at its own value (used if it turns
// out to be an indirect operand) and enters the execute stage input register;
// from there it executes against the registered read data and loads the output
// register. A memory write in the execute cycle is forwarded to a read issued in
// the same cycle. The 256-entry memory reads as zero after reset through per-entry
// valid bits, so no clearing pass is needed and words are accepted right after
// reset. The input only stalls when an out result waits on a full, unaccepted
// output register.
module byte_serial_command_cpu_core #(
    parameter int MEM_DEPTH = bsc_pkg::MEM_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bsc_pkg::BYTE_W-1:0]  i_program_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bsc_pkg::BYTE_W-1:0]  o_out_value
);
    import bsc_pkg::*;

    // execute stage input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_value;

    logic              in_acc;
    logic              s1_adv;
    logic [BYTE_W-1:0] mem_data;
    t_mem_wr           wr;
    t_exec_out         exo;

    // an executing word only blocks if it emits into an occupied result slot that is not being drained
    assign s1_adv     = r_s1_valid && (!exo.out_en || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    bsc_mem #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_program_byte),
        .i_wr      (wr),
        .o_rd_data (mem_data)
    );

    bsc_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_adv),
        .i_byte     (r_s1_byte),
        .i_mem_data (mem_data),
        .o_wr       (wr),
        .o_res      (exo)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte <= i_program_byte;
        end
        if (s1_adv && exo.out_en) begin
            r_out_value <= exo.out_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && exo.out_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;

    // a held word in execute must be an out waiting on the result slot
    a_stall_only_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> (exo.out_en && r_out_valid && !i_out_ready))
        else $error("execute stage stalled without a pending out");

    // a word never both writes memory and emits a result
    a_wr_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr.we && exo.out_en))
        else $error("memory write and out result in the same word");

    // writes happen only when the execute stage fires
    a_wr_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.we |-> s1_adv)
        else $error("memory write without an executing word");

    // an out that leaves execute shows up as a result next cycle
    a_out_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && exo.out_en) |=> o_out_valid)
        else $error("out result lost");

endmodule

>>> dv/byte_serial_command_cpu_core_tb.sv
// Self-checking testbench for byte_serial_command_cpu_core: program words in,
// out words checked in order against an in-bench model of the command language.
// Depends on bsc_pkg and the RTL under sv/.
module byte_serial_command_cpu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;   // long output back-pressure stretch
    localparam int RANDOM_WORDS = 1350;
    localparam int DRAIN_CYCLES = 16;    // margin before the final check

    // ------------------------------------------------------------------
    // Scoreboard: runs the command language on every accepted program word
    // and keeps the out words it should produce, oldest first.
    // ------------------------------------------------------------------
    class out_word_board;
        bit [7:0]  mem_img [256];
        t_phase    phase     = PH_IDLE;
        t_opcode   opcode    = OP_ADD;
        bit [7:0]  first_opd = '0;
        bit        addr_next = 1'b0;
        bit [7:0]  pending_outs [$];
        int        errors    = 0;

        function void absorb_word(logic [7:0] b);
            bit [7:0] v;
            if (b == BYTE_END) begin
                phase     = PH_IDLE;
                addr_next = 1'b0;
                first_opd = '0;
                return;
            end
            if (phase == PH_IDLE) begin
                if (b < OPC_LIMIT) begin
                    opcode = t_opcode'(b[2:0]);
                    phase  = PH_OP1;
                end else begin
                    phase = PH_SKIP;
                end
                return;
            end
            if (phase == PH_SKIP) return;
            if (b == BYTE_IND) begin
                addr_next = 1'b1;
                return;
            end
            v = addr_next ? mem_img[b] : b;
            addr_next = 1'b0;
            if (phase == PH_OP1) begin
                if (opcode == OP_OUT) begin
                    pending_outs.insert(pending_outs.size(), v);
                    phase = PH_IDLE;
                end else begin
                    first_opd = v;
                    phase     = PH_OP2;
                end
                return;
            end
            phase = PH_IDLE;
            case (opcode)
                OP_ADD:  mem_img[0] = first_opd + v;
                OP_SUB:  mem_img[0] = first_opd - v;
                OP_SET:  mem_img[first_opd] = v;
                OP_IFEQ: if (!(first_opd == v)) phase = PH_SKIP;
                OP_IFNE: if (!(first_opd != v)) phase = PH_SKIP;
                OP_IFGT: if (!(first_opd > v))  phase = PH_SKIP;
                default: if (!(first_opd < v))  phase = PH_SKIP;
            endcase
            first_opd = '0;
        endfunction

        function void check_out_word(logic [7:0] got);
            bit [7:0] want;
            if (pending_outs.size() == 0) begin
                $display("%0t: out word 0x%02h with none expected", $time, got);
                errors++;
                return;
            end
            want = pending_outs.pop_front();
            if (got !== want) begin
                $display("%0t: out_value mismatch, expected 0x%02h, actual 0x%02h",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_program_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_value;

    always #6 i_clk = ~i_clk;

    byte_serial_command_cpu_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_program_byte (i_program_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_value    (o_out_value)
    );

    out_word_board sb = new();

    int words_sent  = 0;
    int burst_left  = 0;   // words still to send with no idle gap
    int cycle_cnt   = 0;
    bit out_hold_req = 1'b0;

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the edge, before any NBA lands.
    // An out word never leaves in the cycle its last program word enters,
    // so the order of the two calls does not matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_out_word(o_out_value);
            end
            if (i_in_valid && o_in_ready)
                sb.absorb_word(i_program_byte);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("byte_serial_command_cpu_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random ready stretches, plus one long hold on request
    // so the output register fills and the input channel stalls.
    // ------------------------------------------------------------------
    initial begin
        int r;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (out_hold_req) begin
                out_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    if (r < 85)      repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    else if (r < 97) repeat ($urandom_range(4, 12)) @(posedge i_clk);
                    else             repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------

    // idle gap before a word: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] opc(t_opcode o);
        return {5'b0, o};
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    // Valid is never dropped between back-to-back words.
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_program_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Stop offering words until every expected out word has left.
    task automatic drain_outs();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outs.size() != 0) @(posedge i_clk);
    endtask

    // addresses cluster low so set and indirect reads hit the same entries
    function automatic logic [7:0] rand_addr();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 8'hFD));
    endfunction

    task automatic send_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            send_word(8'($urandom_range(0, 8'hFD)));
        end else begin
            send_word(BYTE_IND);
            if (r >= 95) send_word(BYTE_IND);   // repeated mark
            send_word(rand_addr());
        end
    endtask

    task automatic send_command(input t_opcode op, input bit may_break);
        int n;
        n = (op == OP_OUT) ? 1 : 2;
        send_word(opc(op));
        for (int i = 0; i < n; i++) begin
            // a broken command: end byte in place of an operand
            if (may_break && $urandom_range(0, 99) < 8) begin
                send_word(BYTE_END);
                return;
            end
            send_operand();
        end
    endtask

    function automatic t_opcode rand_op();
        if ($urandom_range(0, 99) < 25) return OP_OUT;
        return t_opcode'($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int      r;
        t_opcode op;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_program_byte <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // out of the largest direct value
        send_word(opc(OP_OUT)); send_word(8'hFD);
        // add with a repeated indirect mark; memory reads zero after reset
        send_word(opc(OP_ADD)); send_word(BYTE_IND); send_word(BYTE_IND);
        send_word(8'h05); send_word(8'hFD);
        // set through an indirect second operand, then read it back
        send_word(opc(OP_SET)); send_word(8'h80); send_word(BYTE_IND); send_word(8'h00);
        send_word(opc(OP_OUT)); send_word(BYTE_IND); send_word(8'h80);
        // sub wraps below zero
        send_word(opc(OP_SUB)); send_word(8'h00); send_word(8'h01);
        // passing ifeq, then failing ifne whose body gets skipped
        send_word(opc(OP_IFEQ)); send_word(8'h01); send_word(8'h01);
        send_word(opc(OP_IFNE)); send_word(8'h02); send_word(8'h02);
        send_word(opc(OP_OUT)); send_word(8'h09); send_word(BYTE_END);
        // ifgt and iflt at the extremes, both hold
        send_word(opc(OP_IFGT)); send_word(8'hFD); send_word(8'h00);
        send_word(opc(OP_IFLT)); send_word(8'h00); send_word(8'hFD);
        // end byte while waiting for an address
        send_word(opc(OP_OUT)); send_word(BYTE_IND); send_word(BYTE_END);
        // unknown first bytes swallow up to the end byte
        send_word(8'h08); send_word(opc(OP_OUT)); send_word(8'h03); send_word(BYTE_END);
        send_word(BYTE_IND); send_word(BYTE_END);
        // idle end byte, then out of the wrapped difference (0xFF)
        send_word(BYTE_END);
        send_word(opc(OP_OUT)); send_word(BYTE_IND); send_word(8'h00);

        // --- back-pressure: long output hold while outs keep coming ---
        // wait until the output side has actually started its hold
        out_hold_req = 1'b1;
        wait (out_hold_req == 1'b0);
        burst_left   = 1000;
        for (int i = 0; i < 30; i++) send_command(OP_OUT, 1'b0);
        burst_left = 0;
        // sender pause until everything is out
        drain_outs();

        // --- random ---
        while (words_sent < RANDOM_WORDS) begin
            // occasional stretch with no input idling
            if (burst_left == 0 && $urandom_range(0, 99) < 4)
                burst_left = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // noise byte; often closed so a skip does not run long
                send_word(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0) send_word(BYTE_END);
            end else if (r < 14) begin
                send_word(BYTE_END);
            end else begin
                op = rand_op();
                send_command(op, 1'b1);
                if (op inside {OP_IFEQ, OP_IFNE, OP_IFGT, OP_IFLT} &&
                    $urandom_range(0, 99) < 80) begin
                    // body runs or is skipped depending on the test
                    if ($urandom_range(0, 99) < 60) send_command(rand_op(), 1'b0);
                    send_word(BYTE_END);
                end
            end
            if ($urandom_range(0, 299) == 0) drain_outs();
        end

        // --- wind down ---
        drain_outs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_outs.size() == 0)
            $display("byte_serial_command_cpu_core_tb: done, clean");
        else
            $display("byte_serial_command_cpu_core_tb: done, errors");
        $finish;
    end

endmodule
